// ===== hw/rtl/lexical_token_scanner_core_macros.svh =====
// Assertion macros for the token scanner core.
// Used by lexical_token_scanner_core; expects clock and reset in scope.
`ifndef LEXICAL_TOKEN_SCANNER_CORE_MACROS_SVH
`define LEXICAL_TOKEN_SCANNER_CORE_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define LTS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define LTS_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/lts_pkg.sv =====
// Types, codes and keyword table for the token scanner core.
// No dependencies.
package lts_pkg;

   localparam int LINE_MAX = 256;
   localparam logic [7:0] COL_CAP = (LINE_MAX - 1 > 255) ? 8'd255 : 8'(LINE_MAX - 1);
   localparam logic [5:0] LEN_CAP = 6'd63;
   localparam int KW_BYTES = 5;
   localparam logic [5:0] KW_BYTES_LEN = 6'(KW_BYTES);
   localparam int QDEPTH = 4;
   localparam int QIDX_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      CLS_NUM = 3'd0,
      CLS_KEY = 3'd1,
      CLS_ID  = 3'd2,
      CLS_OP  = 3'd3,
      CLS_DIV = 3'd4,
      CLS_ERR = 3'd5,
      CLS_END = 3'd6
   } token_class_type;

   typedef enum logic [3:0] {
      OP_LT     = 4'd0,
      OP_LE     = 4'd1,
      OP_NE     = 4'd2,
      OP_ASSIGN = 4'd3,
      OP_EQ     = 4'd4,
      OP_GT     = 4'd5,
      OP_GE     = 4'd6,
      OP_PLUS   = 4'd7,
      OP_MINUS  = 4'd8,
      OP_STAR   = 4'd9,
      OP_SLASH  = 4'd10,
      OP_LPAREN = 4'd11,
      OP_RPAREN = 4'd12,
      OP_SEMI   = 4'd13,
      OP_QUOTE  = 4'd14
   } op_code_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_NUM  = 4'b0010,
      ST_ID   = 4'b0100,
      ST_OP   = 4'b1000
   } scan_state_type;

   typedef struct packed {
      token_class_type cls;
      logic [7:0]      start;
      logic [5:0]      len;
      logic [2:0]      kw;
      logic [3:0]      op;
      logic [7:0]      bad;
      logic            last;
   } token_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] idx;
   } kw_hit_type;

   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_SPACE = 8'd32;

   // Keyword text, first byte in the low bits, zero padded to five bytes.
   localparam logic [KW_BYTES*8-1:0] KW_TEXT [6] = '{
      {8'd0, 8'd0, 8'd0, "f", "i"},
      {8'd0, "e", "s", "l", "e"},
      {"e", "l", "i", "h", "w"},
      {8'd0, 8'd0, 8'd0, "o", "d"},
      {8'd0, 8'd0, "t", "n", "i"},
      {"t", "a", "o", "l", "f"}
   };
   localparam logic [5:0] KW_LEN [6] = '{6'd2, 6'd4, 6'd5, 6'd2, 6'd3, 6'd5};

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic kw_hit_type keyword_of(input logic [KW_BYTES*8-1:0] chars,
                                             input logic [5:0] len);
      kw_hit_type r;
      r = '0;
      for (int k = 5; k >= 0; k--) begin
         if ((len == KW_LEN[k]) && (chars == KW_TEXT[k])) begin
            r.hit = 1'b1;
            r.idx = 3'(k);
         end
      end
      return r;
   endfunction

   function automatic token_type make_tok(input token_class_type cls, input logic [7:0] start,
                                          input logic [5:0] len, input logic [2:0] kw,
                                          input logic [3:0] op, input logic [7:0] bad);
      token_type t;
      t.cls   = cls;
      t.start = start;
      t.len   = len;
      t.kw    = kw;
      t.op    = op;
      t.bad   = bad;
      t.last  = 1'b0;
      return t;
   endfunction

endpackage

// ===== hw/rtl/lexical_token_scanner_core.sv =====
// Token scanner core: one source byte per beat in, finished tokens out.
// Each finished token is written into the result queue and read out on rsp_.
// Throughput: one input beat per cycle unless stalled; a beat may yield two
// tokens, and the four-entry result queue stalls req_ when it holds more than
// two tokens. Reset (synchronous) empties the queue, clears the scan state.
`include "lexical_token_scanner_core_macros.svh"

module lexical_token_scanner_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_ch,
   input  logic                     req_end_of_stream,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lts_pkg::token_class_type rsp_token_class,
   output logic [7:0]               rsp_token_start,
   output logic [5:0]               rsp_token_length,
   output logic [2:0]               rsp_keyword_index,
   output logic [3:0]               rsp_operator_code,
   output logic [7:0]               rsp_bad_char,
   output logic                     rsp_last
);
   import lts_pkg::*;

   scan_state_type state_ff, state_in;
   logic [7:0]  column_ff, column_in;
   logic [7:0]  start_ff, start_in;
   logic [5:0]  len_ff, len_in;
   logic [KW_BYTES*8-1:0] chars_ff, chars_in;
   logic [3:0]  pend_ff, pend_in;

   token_type   q_ff [QDEPTH];
   logic [QIDX_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic        req_accept, rsp_accept;
   token_type   tok_a, tok_b, tok_first, tok_second;
   logic        va, vb;
   logic [1:0]  push_n;
   logic        used;
   logic [3:0]  ext_code;
   logic        ext_ok;
   logic [7:0]  c;
   kw_hit_type  kw_hit;
   logic [7:0]  col_next;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = count_ff > QCNT_W'(QDEPTH - 2);
   assign c          = req_ch;
   assign kw_hit     = keyword_of(chars_ff, len_ff);
   assign col_next   = (column_ff < COL_CAP) ? column_ff + 8'd1 : column_ff;

   // Extension of a pending < = or > into a two-character operator.
   always_comb begin
      ext_ok   = 1'b1;
      ext_code = OP_LT;
      if (pend_ff == OP_LT && c == "=") ext_code = OP_LE;
      else if (pend_ff == OP_LT && c == ">") ext_code = OP_NE;
      else if (pend_ff == OP_ASSIGN && c == "=") ext_code = OP_EQ;
      else if (pend_ff == OP_GT && c == "=") ext_code = OP_GE;
      else ext_ok = 1'b0;
   end

   always_comb begin
      state_in  = state_ff;
      column_in = column_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      chars_in  = chars_ff;
      pend_in   = pend_ff;
      va        = 1'b0;
      vb        = 1'b0;
      tok_b     = make_tok(CLS_END, column_ff, 6'd0, 3'd0, 4'd0, 8'd0);
      used      = 1'b0;

      // Flush candidate: whatever token is pending in the current state.
      tok_a = make_tok(CLS_NUM, start_ff, len_ff, 3'd0, 4'd0, 8'd0);
      unique case (state_ff)
         ST_IDLE: va = 1'b0;
         ST_NUM:  va = 1'b1;
         ST_ID: begin
            va = 1'b1;
            tok_a = kw_hit.hit ? make_tok(CLS_KEY, start_ff, len_ff, kw_hit.idx, 4'd0, 8'd0)
                               : make_tok(CLS_ID, start_ff, len_ff, 3'd0, 4'd0, 8'd0);
         end
         ST_OP: begin
            va = 1'b1;
            tok_a = make_tok(CLS_OP, start_ff, 6'd1, 3'd0, pend_ff, 8'd0);
         end
         default: va = 1'b0;
      endcase

      if (req_end_of_stream) begin
         vb        = 1'b1;
         state_in  = ST_IDLE;
         column_in = '0;
         start_in  = '0;
         len_in    = '0;
         chars_in  = '0;
         pend_in   = '0;
      end else if (c == CH_LF || c == CH_NUL) begin
         state_in  = ST_IDLE;
         column_in = '0;
         len_in    = '0;
         chars_in  = '0;
         pend_in   = '0;
      end else begin
         column_in = col_next;
         unique case (state_ff)
            ST_IDLE: used = 1'b0;
            ST_NUM: begin
               if (is_digit(c) || c == ".") begin
                  used = 1'b1;
                  if (len_ff < LEN_CAP) len_in = len_ff + 6'd1;
               end
            end
            ST_ID: begin
               if (is_letter(c) || is_digit(c) || c == "_") begin
                  used = 1'b1;
                  for (int i = 0; i < KW_BYTES; i++) begin
                     if (len_ff == 6'(i)) chars_in[i*8 +: 8] = c;
                  end
                  if (len_ff < LEN_CAP) len_in = len_ff + 6'd1;
               end
            end
            ST_OP: begin
               if (ext_ok) begin
                  used     = 1'b1;
                  tok_a    = make_tok(CLS_OP, start_ff, 6'd2, 3'd0, ext_code, 8'd0);
                  state_in = ST_IDLE;
                  pend_in  = '0;
               end
            end
            default: used = 1'b0;
         endcase

         if (used) begin
            // Pending token either absorbed the byte or completed as a pair.
            va = (state_ff == ST_OP);
         end else begin
            // Drop the pending token out, then scan the byte afresh.
            state_in = ST_IDLE;
            len_in   = '0;
            chars_in = '0;
            pend_in  = '0;
            if (c == CH_SPACE || c == CH_TAB) begin
               vb = 1'b0;
            end else if (is_digit(c)) begin
               state_in = ST_NUM;
               start_in = column_ff;
               len_in   = 6'd1;
            end else if (is_letter(c)) begin
               state_in = ST_ID;
               start_in = column_ff;
               len_in   = 6'd1;
               chars_in = {{(KW_BYTES-1)*8{1'b0}}, c};
            end else begin
               vb = 1'b1;
               case (c)
                  "<": begin
                     vb = 1'b0; state_in = ST_OP; start_in = column_ff; pend_in = OP_LT;
                  end
                  "=": begin
                     vb = 1'b0; state_in = ST_OP; start_in = column_ff; pend_in = OP_ASSIGN;
                  end
                  ">": begin
                     vb = 1'b0; state_in = ST_OP; start_in = column_ff; pend_in = OP_GT;
                  end
                  "+": tok_b = make_tok(CLS_OP, column_ff, 6'd1, 3'd0, OP_PLUS, 8'd0);
                  "-": tok_b = make_tok(CLS_OP, column_ff, 6'd1, 3'd0, OP_MINUS, 8'd0);
                  "*": tok_b = make_tok(CLS_OP, column_ff, 6'd1, 3'd0, OP_STAR, 8'd0);
                  "/": tok_b = make_tok(CLS_OP, column_ff, 6'd1, 3'd0, OP_SLASH, 8'd0);
                  "(": tok_b = make_tok(CLS_DIV, column_ff, 6'd1, 3'd0, OP_LPAREN, 8'd0);
                  ")": tok_b = make_tok(CLS_DIV, column_ff, 6'd1, 3'd0, OP_RPAREN, 8'd0);
                  ";": tok_b = make_tok(CLS_DIV, column_ff, 6'd1, 3'd0, OP_SEMI, 8'd0);
                  "'": tok_b = make_tok(CLS_DIV, column_ff, 6'd1, 3'd0, OP_QUOTE, 8'd0);
                  default: tok_b = make_tok(CLS_ERR, column_ff, 6'd1, 3'd0, 4'd0, c);
               endcase
            end
         end
      end
   end

   // Pack up to two tokens into the queue, marking the final one of the beat.
   always_comb begin
      tok_first  = va ? tok_a : tok_b;
      tok_second = tok_b;
      tok_first.last  = !(va && vb);
      tok_second.last = 1'b1;
      push_n = req_accept ? (2'(va) + 2'(vb)) : 2'd0;
   end

   assign wp_in    = wp_ff + QIDX_W'(push_n);
   assign rp_in    = rp_ff + QIDX_W'(rsp_accept);
   assign count_in = count_ff + QCNT_W'(push_n) - QCNT_W'(rsp_accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         column_ff <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         chars_ff  <= '0;
         pend_ff   <= '0;
         wp_ff     <= '0;
         rp_ff     <= '0;
         count_ff  <= '0;
      end else begin
         if (req_accept) begin
            state_ff  <= state_in;
            column_ff <= column_in;
            start_ff  <= start_in;
            len_ff    <= len_in;
            chars_ff  <= chars_in;
            pend_ff   <= pend_in;
         end
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_ff[wp_ff] <= tok_first;
      end
      if (push_n == 2'd2) begin
         q_ff[wp_ff + QIDX_W'(1)] <= tok_second;
      end
   end

   assign rsp_valid         = count_ff != '0;
   assign rsp_token_class   = q_ff[rp_ff].cls;
   assign rsp_token_start   = q_ff[rp_ff].start;
   assign rsp_token_length  = q_ff[rp_ff].len;
   assign rsp_keyword_index = q_ff[rp_ff].kw;
   assign rsp_operator_code = q_ff[rp_ff].op;
   assign rsp_bad_char      = q_ff[rp_ff].bad;
   assign rsp_last          = q_ff[rp_ff].last;

   `LTS_NEVER(a_queue_overflow, count_ff > QCNT_W'(QDEPTH), "result queue overflow")
   `LTS_ASSERT(a_accept_room, req_accept |-> count_ff <= QCNT_W'(QDEPTH - 2), "accept without room for two tokens")
   `LTS_ASSERT(a_pop_only, (rsp_accept && push_n == 2'd0) |=> count_ff == $past(count_ff) - QCNT_W'(1), "queue count slip on pop")
   `LTS_ASSERT(a_len_idle, (state_ff == ST_IDLE || state_ff == ST_OP) |-> len_ff == '0, "token length left over outside a token")

endmodule
